@@ src/bdpc_pkg.sv @@
package bdpc_pkg;

	localparam int TIME_BITS_DEF = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int TALLY_W       = 4;

	localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd40;
	localparam logic [CFG_W-1:0]   DOUBLE_RST   = 16'd300;
	localparam logic [CFG_W-1:0]   LONG_RST     = 16'd1000;
	localparam logic [TALLY_W-1:0] TALLY_MAX    = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_DOUBLE   = 2'd1,
		CFG_LONG     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] double_press_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic               pressed;
		logic               long_press;
		logic               double_press;
		logic               single_press;
		logic [TALLY_W-1:0] press_count;
	} res_t;

endpackage

@@ src/bdpc_tick.sv @@
module bdpc_tick #(
	parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
	input  logic                         raw,
	input  bdpc_pkg::cfg_t               cfg,
	input  logic                         prev_raw,
	input  logic                         debounced,
	input  logic [TIME_BITS-1:0]         stable_ticks,
	input  logic [TIME_BITS-1:0]         since_ticks,
	input  logic [bdpc_pkg::TALLY_W-1:0] tally,
	output logic                         debounced_nxt,
	output logic [TIME_BITS-1:0]         stable_nxt,
	output logic [TIME_BITS-1:0]         since_nxt,
	output logic [bdpc_pkg::TALLY_W-1:0] tally_nxt,
	output bdpc_pkg::res_t               res
);

	// compare width covers both the counters and the 16-bit settings
	localparam int CMP_W = (TIME_BITS > bdpc_pkg::CFG_W) ? TIME_BITS : bdpc_pkg::CFG_W;

	logic [TIME_BITS-1:0]         stable_inc;
	logic [TIME_BITS-1:0]         since_inc;
	logic                         flip;
	logic                         new_press;
	logic [bdpc_pkg::TALLY_W-1:0] tally_mid;
	logic                         single;

	always_comb begin
		stable_inc = (&stable_ticks) ? stable_ticks : stable_ticks + 1'b1;
		since_inc  = (&since_ticks) ? since_ticks : since_ticks + 1'b1;

		stable_nxt = (raw != prev_raw) ? '0 : stable_inc;

		flip      = (CMP_W'(stable_nxt) > CMP_W'(cfg.debounce_ms)) && (raw != debounced);
		new_press = flip && raw;
		debounced_nxt = flip ? raw : debounced;

		tally_mid = tally;
		if (new_press) begin
			if (CMP_W'(since_inc) < CMP_W'(cfg.double_press_ms)) begin
				if (tally != bdpc_pkg::TALLY_MAX)
					tally_mid = tally + 1'b1;
			end else begin
				tally_mid = bdpc_pkg::TALLY_W'(1);
			end
		end
		since_nxt = new_press ? '0 : since_inc;

		// single press fires once the repeat window has run out
		single = (tally_mid == bdpc_pkg::TALLY_W'(1))
			&& (CMP_W'(since_nxt) >= CMP_W'(cfg.double_press_ms));
		tally_nxt = single ? '0 : tally_mid;

		res.pressed      = debounced_nxt;
		res.long_press   = debounced_nxt && (CMP_W'(since_nxt) > CMP_W'(cfg.long_press_ms));
		res.double_press = (tally_mid >= bdpc_pkg::TALLY_W'(2));
		res.single_press = single;
		res.press_count  = tally_nxt;
	end

endmodule

@@ src/button_debounce_press_classifier.sv @@
// Button debounce and press classifier.
// Input channel (in_valid/in_ready, raw_level): one transfer per millisecond
// tick carrying the sampled pin level. Output channel (out_valid/out_ready):
// exactly one result per input transfer with the debounced level, long,
// double and single press flags and the running press count.
// The result is registered at the edge that takes the input. Throughput is
// one tick per cycle while results drain; the tick logic is a few saturating
// increments and compares between the state registers and the result register.
// in_ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds off new ticks only while its result waits.
// Configuration: cfg_we with cfg_index/cfg_data writes debounce time (0),
// double press window (1) or long press time (2); other indexes are ignored.
// Write only while idle.
// Reset: settings return to 40/300/1000, debounced level open, press count
// zero, time since last press saturated, result register empty.
module button_debounce_press_classifier #(
	parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           raw_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pressed,
	output logic                           long_press,
	output logic                           double_press,
	output logic                           single_press,
	output logic [bdpc_pkg::TALLY_W-1:0]   press_count
);

	bdpc_pkg::cfg_t               cfg_q;
	logic                         prev_raw_q;
	logic                         debounced_q;
	logic [TIME_BITS-1:0]         stable_q;
	logic [TIME_BITS-1:0]         since_q;
	logic [bdpc_pkg::TALLY_W-1:0] tally_q;
	logic                         out_valid_q;
	bdpc_pkg::res_t               res_q;

	logic                         debounced_nxt;
	logic [TIME_BITS-1:0]         stable_nxt;
	logic [TIME_BITS-1:0]         since_nxt;
	logic [bdpc_pkg::TALLY_W-1:0] tally_nxt;
	bdpc_pkg::res_t               res_nxt;
	logic                         in_xfer;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bdpc_pkg::DEBOUNCE_RST;
			cfg_q.double_press_ms <= bdpc_pkg::DOUBLE_RST;
			cfg_q.long_press_ms   <= bdpc_pkg::LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bdpc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				bdpc_pkg::CFG_DOUBLE:   cfg_q.double_press_ms <= cfg_data;
				bdpc_pkg::CFG_LONG:     cfg_q.long_press_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	bdpc_tick #(
		.TIME_BITS(TIME_BITS)
	) u_tick (
		.raw          (raw_level),
		.cfg          (cfg_q),
		.prev_raw     (prev_raw_q),
		.debounced    (debounced_q),
		.stable_ticks (stable_q),
		.since_ticks  (since_q),
		.tally        (tally_q),
		.debounced_nxt(debounced_nxt),
		.stable_nxt   (stable_nxt),
		.since_nxt    (since_nxt),
		.tally_nxt    (tally_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= 1'b0;
			debounced_q <= 1'b0;
			stable_q    <= '0;
			since_q     <= '1;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				prev_raw_q  <= raw_level;
				debounced_q <= debounced_nxt;
				stable_q    <= stable_nxt;
				since_q     <= since_nxt;
				tally_q     <= tally_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			res_q <= res_nxt;
	end

	assign out_valid    = out_valid_q;
	assign pressed      = res_q.pressed;
	assign long_press   = res_q.long_press;
	assign double_press = res_q.double_press;
	assign single_press = res_q.single_press;
	assign press_count  = res_q.press_count;

endmodule

@@ src/bdpc_checker.sv @@
module bdpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         pressed,
	input logic                         long_press,
	input logic                         double_press,
	input logic                         single_press,
	input logic [bdpc_pkg::TALLY_W-1:0] press_count
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressed) && $stable(long_press)
			&& $stable(double_press) && $stable(single_press) && $stable(press_count))
		else $error("result changed while stalled");

	// every input transfer yields a result on the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("input transfer without result");

	a_long_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_press |-> pressed)
		else $error("long press while released");

	// single press clears the count; double press needs a tally of two or more
	a_single_clr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && single_press |-> press_count == '0 && !double_press)
		else $error("single press with count left");

	a_double_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && double_press |-> press_count >= bdpc_pkg::TALLY_W'(2))
		else $error("double press with low count");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);
